// ===== design/jif_pkg.sv =====
// jif_pkg: shared constants, types and microcode ROM of the JSON indent formatter.
// No dependencies; used by every other file of the block.
package jif_pkg;

   localparam int CHAR_W      = 16;
   localparam int MAX_LEVEL   = 15;
   localparam int MIN_LEVEL   = -16;
   localparam int INDENT_STEP = 4;
   localparam int LVL_W       = 5;
   localparam int CNT_W       = $clog2(MAX_LEVEL * INDENT_STEP + 1);
   localparam int UPC_W       = 4;

   localparam logic [CHAR_W-1:0] CH_NL    = CHAR_W'(10);
   localparam logic [CHAR_W-1:0] CH_SP    = CHAR_W'(32);
   localparam logic [CHAR_W-1:0] CH_QUOTE = CHAR_W'(8'h22);
   localparam logic [CHAR_W-1:0] CH_COMMA = CHAR_W'(8'h2C);
   localparam logic [CHAR_W-1:0] CH_COLON = CHAR_W'(8'h3A);
   localparam logic [CHAR_W-1:0] CH_LSQ   = CHAR_W'(8'h5B);
   localparam logic [CHAR_W-1:0] CH_RSQ   = CHAR_W'(8'h5D);
   localparam logic [CHAR_W-1:0] CH_LBR   = CHAR_W'(8'h7B);
   localparam logic [CHAR_W-1:0] CH_RBR   = CHAR_W'(8'h7D);

   typedef logic [CHAR_W-1:0]         char_type;
   typedef logic signed [LVL_W-1:0]   level_type;
   typedef logic signed [LVL_W+1:0]   wlevel_type;
   typedef logic [CNT_W-1:0]          cnt_type;
   typedef logic [UPC_W-1:0]          upc_type;

   // word source selected by a microcode step
   typedef enum logic [1:0] {
      SRC_CHAR,
      SRC_NL,
      SRC_SP
   } src_type;

   // branch condition of a microcode step
   typedef enum logic [1:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_ZERO,
      COND_ONE
   } cond_type;

   typedef struct packed {
      src_type  src;
      logic     dec;      // count down the space counter
      cond_type cond;
      upc_type  next_pc;  // branch not taken
      upc_type  jmp_pc;   // branch taken
      logic     jmp_end;  // taken branch finishes the input word
   } uword_type;

   // sequencer status seen by the datapath
   typedef struct packed {
      logic    busy;
      src_type src;
      logic    last;
   } useq_stat_type;

   // program entry points
   localparam upc_type UPC_PLAIN    = UPC_W'(0);
   localparam upc_type UPC_COLON    = UPC_W'(1);
   localparam upc_type UPC_COLON_SP = UPC_W'(2);
   localparam upc_type UPC_OPEN     = UPC_W'(3);
   localparam upc_type UPC_OPEN_NL  = UPC_W'(4);
   localparam upc_type UPC_OPEN_SP  = UPC_W'(5);
   localparam upc_type UPC_CLOSE    = UPC_W'(6);
   localparam upc_type UPC_CLOSE_SP = UPC_W'(7);
   localparam upc_type UPC_CLOSE_CH = UPC_W'(8);

   function automatic uword_type ucode_rom(input upc_type pc);
      uword_type w;
      w = '{SRC_CHAR, 1'b0, COND_ALWAYS, UPC_PLAIN, UPC_PLAIN, 1'b1};
      unique case (pc)
         UPC_PLAIN:    w = '{SRC_CHAR, 1'b0, COND_ALWAYS, UPC_PLAIN,    UPC_PLAIN,    1'b1};
         UPC_COLON:    w = '{SRC_CHAR, 1'b0, COND_NEVER,  UPC_COLON_SP, UPC_PLAIN,    1'b0};
         UPC_COLON_SP: w = '{SRC_SP,   1'b0, COND_ALWAYS, UPC_PLAIN,    UPC_PLAIN,    1'b1};
         UPC_OPEN:     w = '{SRC_CHAR, 1'b0, COND_NEVER,  UPC_OPEN_NL,  UPC_PLAIN,    1'b0};
         UPC_OPEN_NL:  w = '{SRC_NL,   1'b0, COND_ZERO,   UPC_OPEN_SP,  UPC_PLAIN,    1'b1};
         UPC_OPEN_SP:  w = '{SRC_SP,   1'b1, COND_ONE,    UPC_OPEN_SP,  UPC_PLAIN,    1'b1};
         UPC_CLOSE:    w = '{SRC_NL,   1'b0, COND_ZERO,   UPC_CLOSE_SP, UPC_CLOSE_CH, 1'b0};
         UPC_CLOSE_SP: w = '{SRC_SP,   1'b1, COND_ONE,    UPC_CLOSE_SP, UPC_CLOSE_CH, 1'b0};
         UPC_CLOSE_CH: w = '{SRC_CHAR, 1'b0, COND_ALWAYS, UPC_PLAIN,    UPC_PLAIN,    1'b1};
         default:      w = '{SRC_CHAR, 1'b0, COND_ALWAYS, UPC_PLAIN,    UPC_PLAIN,    1'b1};
      endcase
      return w;
   endfunction

   function automatic level_type sat_level(input wlevel_type v);
      level_type r;
      if (int'(v) > MAX_LEVEL)
         r = level_type'(MAX_LEVEL);
      else if (int'(v) < MIN_LEVEL)
         r = level_type'(MIN_LEVEL);
      else
         r = level_type'(v);
      return r;
   endfunction

   // indent width; zero or negative level gives no spaces
   function automatic cnt_type indent_cnt(input wlevel_type v);
      cnt_type r;
      if (int'(v) > 0)
         r = cnt_type'(int'(v) * INDENT_STEP);
      else
         r = '0;
      return r;
   endfunction

endpackage

// ===== design/jif_req_if.sv =====
// jif_req_if: input channel of the JSON indent formatter (valid/ready plus one word).
// Depends on jif_pkg.
interface jif_req_if;
   logic               valid;
   logic               ready;
   jif_pkg::char_type  char_in;
   logic               start_req;

   modport source (output valid, output char_in, output start_req, input ready);
   modport sink   (input valid, input char_in, input start_req, output ready);
endinterface

// ===== design/jif_rsp_if.sv =====
// jif_rsp_if: result channel of the JSON indent formatter (valid/ready plus one word).
// Depends on jif_pkg.
interface jif_rsp_if;
   logic               valid;
   logic               ready;
   jif_pkg::char_type  char_out;
   logic               last;

   modport source (output valid, output char_out, output last, input ready);
   modport sink   (input valid, input char_out, input last, output ready);
endinterface

// ===== design/jif_useq.sv =====
// jif_useq: microcode sequencer; step counter, space counter and control ROM.
// Depends on jif_pkg (ROM, word and status types).
module jif_useq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  jif_pkg::upc_type        entry,
   input  jif_pkg::cnt_type        count,
   input  logic                    advance,
   output jif_pkg::useq_stat_type  stat
);

   jif_pkg::upc_type   pc_ff, pc_in;
   jif_pkg::cnt_type   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   jif_pkg::uword_type uw;
   logic               taken;
   logic               step;

   always_comb begin
      uw = jif_pkg::ucode_rom(pc_ff);
      unique case (uw.cond)
         jif_pkg::COND_NEVER:  taken = 1'b0;
         jif_pkg::COND_ALWAYS: taken = 1'b1;
         jif_pkg::COND_ZERO:   taken = (cnt_ff == '0);
         jif_pkg::COND_ONE:    taken = (cnt_ff == jif_pkg::cnt_type'(1));
         default:              taken = 1'b1;
      endcase
   end

   assign step      = busy_ff && advance;
   assign stat.busy = busy_ff;
   assign stat.src  = uw.src;
   assign stat.last = taken && uw.jmp_end;

   always_comb begin
      pc_in   = pc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (step) begin
         pc_in = taken ? uw.jmp_pc : uw.next_pc;
         if (uw.dec)
            cnt_in = cnt_ff - jif_pkg::cnt_type'(1);
         if (taken && uw.jmp_end)
            busy_in = 1'b0;
      end
      if (load) begin
         pc_in   = entry;
         cnt_in  = count;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= jif_pkg::UPC_PLAIN;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
      cnt_ff <= cnt_in;
   end

endmodule

// ===== design/json_indent_formatter_unit.sv =====
// json_indent_formatter_unit: adds line breaks and indentation to compact JSON text.
// An accepted input word is loaded into the sequencer, which feeds the output register.
// Throughput: one output word per cycle from the microcode sequencer unless the output stalls,
// so an input word yields 1 to 62 output words; the next one is taken as the last goes out.
// Reset (synchronous): level 1, all flags clear, sequencer idle, output register empty.
// Depends on jif_pkg, jif_req_if, jif_rsp_if and jif_useq.
module json_indent_formatter_unit (
   input  logic        clock,
   input  logic        reset,
   jif_req_if.sink     req_if,
   jif_rsp_if.source   rsp_if
);

   jif_pkg::level_type     level_ff, level_in;
   logic                   quote_ff, quote_in;
   logic                   square_ff, square_in;
   logic                   closed_ff, closed_in;
   jif_pkg::char_type      char_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   jif_pkg::char_type      rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   jif_pkg::useq_stat_type stat;
   logic                   advance;
   logic                   accept;
   jif_pkg::upc_type       entry;
   jif_pkg::cnt_type       count;

   jif_pkg::level_type     base_level;
   logic                   base_quote, base_square, base_closed;
   jif_pkg::wlevel_type    base_w;
   jif_pkg::wlevel_type    close_w;
   jif_pkg::level_type     close_level;

   assign advance       = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = !stat.busy || (advance && stat.last);
   assign accept        = req_if.valid && req_if.ready;

   // decode of the incoming word against state (or reset values on start)
   always_comb begin
      base_level  = req_if.start_req ? jif_pkg::level_type'(1) : level_ff;
      base_quote  = req_if.start_req ? 1'b0 : quote_ff;
      base_square = req_if.start_req ? 1'b0 : square_ff;
      base_closed = req_if.start_req ? 1'b0 : closed_ff;
      base_w      = jif_pkg::wlevel_type'(base_level);

      if (req_if.char_in == jif_pkg::CH_RSQ && base_square)
         close_w = base_w - jif_pkg::wlevel_type'(2);
      else
         close_w = base_w - jif_pkg::wlevel_type'(1);
      close_level = jif_pkg::sat_level(close_w);

      level_in  = base_level;
      quote_in  = base_quote;
      square_in = base_square;
      closed_in = base_closed;
      entry     = jif_pkg::UPC_PLAIN;
      count     = '0;

      priority if (req_if.char_in == jif_pkg::CH_LSQ || req_if.char_in == jif_pkg::CH_LBR) begin
         entry     = jif_pkg::UPC_OPEN;
         count     = jif_pkg::indent_cnt(base_w);
         level_in  = jif_pkg::sat_level(base_w + jif_pkg::wlevel_type'(1));
         closed_in = 1'b0;
         if (req_if.char_in == jif_pkg::CH_LSQ)
            square_in = 1'b1;
      end else if (req_if.char_in == jif_pkg::CH_RSQ || req_if.char_in == jif_pkg::CH_RBR) begin
         entry     = jif_pkg::UPC_CLOSE;
         count     = jif_pkg::indent_cnt(jif_pkg::wlevel_type'(close_level));
         level_in  = close_level;
         closed_in = 1'b1;
         if (req_if.char_in == jif_pkg::CH_RSQ && base_square)
            square_in = 1'b0;
      end else if (req_if.char_in == jif_pkg::CH_COMMA && !base_quote) begin
         entry = jif_pkg::UPC_OPEN;
         if (base_closed) begin
            count    = jif_pkg::indent_cnt(base_w);
            level_in = jif_pkg::sat_level(base_w + jif_pkg::wlevel_type'(1));
         end else begin
            count    = jif_pkg::indent_cnt(base_w - jif_pkg::wlevel_type'(1));
         end
      end else if (req_if.char_in == jif_pkg::CH_COLON) begin
         entry = jif_pkg::UPC_COLON;
      end else begin
         if (req_if.char_in == jif_pkg::CH_QUOTE)
            quote_in = !base_quote;
      end
   end

   jif_useq u_useq (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .entry   (entry),
      .count   (count),
      .advance (advance),
      .stat    (stat)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (stat.busy && advance) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = stat.last;
         unique case (stat.src)
            jif_pkg::SRC_CHAR: rsp_char_in = char_ff;
            jif_pkg::SRC_NL:   rsp_char_in = jif_pkg::CH_NL;
            jif_pkg::SRC_SP:   rsp_char_in = jif_pkg::CH_SP;
            default:           rsp_char_in = char_ff;
         endcase
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= jif_pkg::level_type'(1);
         quote_ff     <= 1'b0;
         square_ff    <= 1'b0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            level_ff  <= level_in;
            quote_ff  <= quote_in;
            square_ff <= square_in;
            closed_ff <= closed_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept)
         char_ff <= req_if.char_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.char_out = rsp_char_ff;
   assign rsp_if.last     = rsp_last_ff;

endmodule

// ===== design/jif_checker.sv =====
// jif_checker: port-level assertions for json_indent_formatter_unit, bound to the top.
// Depends on jif_pkg, jif_req_if and jif_rsp_if.
module jif_checker (
   input  logic        clock,
   input  logic        reset,
   jif_req_if.sink     req_if,
   jif_rsp_if.source   rsp_if
);

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("output valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=>
         rsp_if.valid && $stable(rsp_if.char_out) && $stable(rsp_if.last))
      else $error("stalled output word changed");

   // an opening bracket always produces more than one word
   a_open_busy: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready &&
      (req_if.char_in == jif_pkg::CH_LSQ || req_if.char_in == jif_pkg::CH_LBR)
      |=> !req_if.ready)
      else $error("input taken while bracket still expanding");

   a_open_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid &&
      (rsp_if.char_out == jif_pkg::CH_LSQ || rsp_if.char_out == jif_pkg::CH_LBR)
      |-> !rsp_if.last)
      else $error("opening bracket flagged last");

   a_close_last: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid &&
      (rsp_if.char_out == jif_pkg::CH_RSQ || rsp_if.char_out == jif_pkg::CH_RBR)
      |-> rsp_if.last)
      else $error("closing bracket not flagged last");

endmodule

bind json_indent_formatter_unit jif_checker u_jif_checker (
   .clock  (clock),
   .reset  (reset),
   .req_if (req_if),
   .rsp_if (rsp_if)
);
